FILE: design/eht_pkg.sv
// Package for the event handle table: operation codes, status codes, FSM states, entry type, constants.
// No dependencies.
package eht_pkg;

  typedef enum logic [3:0] {
    OP_OPEN          = 4'd0,
    OP_CLOSE         = 4'd1,
    OP_ENABLE        = 4'd2,
    OP_DISABLE       = 4'd3,
    OP_TEST          = 4'd4,
    OP_DELIVER       = 4'd5,
    OP_DELIVER_CLASS = 4'd6,
    OP_UNDELIVER     = 4'd7,
    OP_UNDELIVER_CLS = 4'd8,
    OP_HAS_DELIVERED = 4'd9,
    OP_IS_DELIVERED  = 4'd10,
    OP_CONSUME       = 4'd11,
    OP_READ_ENTRY    = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    ST_FREE      = 2'd0,
    ST_DISABLED  = 2'd1,
    ST_ENABLED   = 2'd2,
    ST_DELIVERED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_RD,
    S_EXEC,
    S_SCAN
  } fsm_t;

  typedef struct packed {
    logic [31:0] cls;
    logic [15:0] spec;
    logic        polled;
    logic [31:0] callback;
    logic [1:0]  status;
  } entry_t;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] TOP_BYTE   = 32'hFF00_0000;
  localparam logic [31:0] HBASE_RST  = 32'hF100_0000;
  localparam int          MAX_RESULTS = 16;

endpackage

FILE: design/event_handle_table.sv
// Event handle table: slots live in one synchronous RAM with registered read.
// Depends on eht_pkg.
//
// After reset the block clears the slot RAM with busy high. A per-handle
// request passes through accept and read (IDLE), execute/write (EXEC) and
// the return to IDLE; the next request can be accepted in the cycle that
// shows the result. Open and class-wide requests scan the RAM one slot per
// cycle; deliver_class adds a tail state (EXEC) when callbacks are collected
// both from the last slot and from an earlier one. Results appear for one
// cycle on out_valid; deliver_class may give one result per scanned slot,
// at most 16, the final one carrying out_last. The receiver cannot stall
// results.
module event_handle_table
  import eht_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_mode,
  input  logic [31:0] in_handle_in,
  input  logic [31:0] in_class_id,
  input  logic [15:0] in_spec_in,
  input  logic        in_no_callback,
  input  logic [31:0] in_callback_in,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_ok,
  output logic [31:0] out_handle_out,
  output logic [31:0] out_entry_class,
  output logic [15:0] out_entry_spec,
  output logic        out_entry_no_callback,
  output logic [1:0]  out_entry_status,
  output logic [31:0] out_callback_out,
  output logic        out_last
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // slot memory
  entry_t mem [SLOT_COUNT];
  entry_t rd_q;
  logic [IW-1:0] raddr, waddr;
  logic          we;
  entry_t        wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  fsm_t state_r, state_nxt;
  logic [31:0] hbase_r;
  logic [3:0]  mode_r;
  logic [31:0] cls_r, cb_r;
  logic [15:0] spec_r;
  logic        pol_r, valid_r;
  logic [IW-1:0] idx_r, idx_nxt;      // address being read / scan pointer
  logic [IW-1:0] pidx_r, pidx_nxt;    // slot whose data sits in rd_q
  logic        found_r, found_nxt;
  logic [4:0]  n_r, n_nxt;
  // pending deliver_class result, held so the final one can carry last
  logic        pend_r, pend_nxt;
  logic [31:0] pcb_r, pcb_nxt;

  // outputs registered
  logic        ov_r, ov_nxt, ook_r, ook_nxt, olast_r, olast_nxt;
  logic [31:0] ohd_r, ohd_nxt, ocb_r, ocb_nxt;
  entry_t      oent_r, oent_nxt;

  // handle decode at accept
  logic [4:0] hidx;
  logic       hval;
  assign hidx = in_handle_in[8:4];
  assign hval = ((in_handle_in & TOP_BYTE) == (hbase_r & TOP_BYTE)) &&
                (32'(hidx) < 32'(SLOT_COUNT));

  logic scan_op;
  assign scan_op = (in_mode == OP_OPEN) || (in_mode == OP_DELIVER_CLASS) ||
                   (in_mode == OP_UNDELIVER_CLS) || (in_mode == OP_HAS_DELIVERED);

  logic last_slot, match;
  assign last_slot = (32'(pidx_r) == SLOT_COUNT - 1);
  assign match = (rd_q.cls == cls_r) && (rd_q.spec == spec_r);

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    pidx_nxt = pidx_r;
    found_nxt = found_r;
    n_nxt = n_r;
    pend_nxt = pend_r;
    pcb_nxt = pcb_r;
    raddr = idx_r;
    we = 1'b0;
    waddr = pidx_r;
    wdata = rd_q;
    ov_nxt = 1'b0;
    ook_nxt = 1'b0;
    olast_nxt = 1'b1;
    ohd_nxt = '0;
    ocb_nxt = '0;
    oent_nxt = '0;
    case (state_r)
      // sweep the RAM to all-free
      S_CLEAR: begin
        we = 1'b1;
        waddr = idx_r;
        wdata = '0;
        idx_nxt = idx_r + 1'b1;
        if (32'(idx_r) == SLOT_COUNT - 1) state_nxt = S_IDLE;
      end
      // accept request, issue first read
      S_IDLE: begin
        if (start) begin
          found_nxt = 1'b0;
          n_nxt = '0;
          pend_nxt = 1'b0;
          if (scan_op) begin
            raddr = '0;
            pidx_nxt = '0;
            idx_nxt = (SLOT_COUNT > 1) ? IW'(1) : '0;
            state_nxt = S_SCAN;
          end else begin
            raddr = hidx[IW-1:0];
            pidx_nxt = hidx[IW-1:0];
            state_nxt = S_EXEC;
          end
        end
      end
      // per-handle read-modify-write
      S_EXEC: begin
        state_nxt = S_IDLE;
        ov_nxt = 1'b1;
        if (valid_r) begin
          case (mode_r)
            OP_CLOSE: begin
              we = 1'b1; wdata = '0; ook_nxt = 1'b1;
            end
            OP_ENABLE, OP_DISABLE: if (rd_q.status != ST_FREE) begin
              we = 1'b1;
              wdata.status = (mode_r == OP_ENABLE) ? ST_ENABLED : ST_DISABLED;
              ook_nxt = 1'b1;
            end
            OP_TEST: if (rd_q.status == ST_DELIVERED) begin
              ook_nxt = 1'b1;
              if (rd_q.polled) begin we = 1'b1; wdata.status = ST_ENABLED; end
            end
            OP_DELIVER: if (rd_q.status == ST_ENABLED && rd_q.polled) begin
              we = 1'b1; wdata.status = ST_DELIVERED; ook_nxt = 1'b1;
            end
            OP_UNDELIVER: if (rd_q.status == ST_DELIVERED) begin
              we = 1'b1; wdata.status = ST_ENABLED; ook_nxt = 1'b1;
            end
            OP_IS_DELIVERED: ook_nxt = (rd_q.status == ST_DELIVERED);
            OP_CONSUME: if (rd_q.status == ST_DELIVERED && rd_q.polled) begin
              we = 1'b1; wdata.status = ST_ENABLED; ook_nxt = 1'b1;
            end
            OP_READ_ENTRY: begin
              ook_nxt = 1'b1;
              oent_nxt = rd_q;
              ocb_nxt = rd_q.callback;
            end
            default: ;
          endcase
        end
      end
      // scan one slot per cycle; rd_q holds slot pidx_r
      S_SCAN: begin
        raddr = idx_r;
        idx_nxt = idx_r + 1'b1;
        pidx_nxt = idx_r;
        case (mode_r)
          OP_OPEN: if (!found_r && rd_q.status == ST_FREE) begin
            found_nxt = 1'b1;
            we = 1'b1;
            wdata.cls = cls_r; wdata.spec = spec_r; wdata.polled = pol_r;
            wdata.callback = cb_r; wdata.status = ST_DISABLED;
            ohd_nxt = hbase_r | (32'(pidx_r) << 4);
          end
          OP_DELIVER_CLASS: if (rd_q.status == ST_ENABLED && match) begin
            if (rd_q.polled) begin
              we = 1'b1; wdata.status = ST_DELIVERED;
            end else if (rd_q.callback != '0 && 32'(n_r) < MAX_RESULTS) begin
              // flush previous pending result, hold this one
              if (pend_r) begin
                ov_nxt = 1'b1; ook_nxt = 1'b1; olast_nxt = 1'b0; ocb_nxt = pcb_r;
              end
              pend_nxt = 1'b1;
              pcb_nxt = rd_q.callback;
              n_nxt = n_r + 1'b1;
            end
          end
          OP_UNDELIVER_CLS: if (rd_q.status == ST_DELIVERED && match) begin
            we = 1'b1; wdata.status = ST_ENABLED; found_nxt = 1'b1;
          end
          OP_HAS_DELIVERED: if (rd_q.status == ST_DELIVERED && match)
            found_nxt = 1'b1;
          default: ;
        endcase
        if (last_slot) begin
          state_nxt = S_IDLE;
          if (mode_r == OP_DELIVER_CLASS) begin
            // final result: the held one, or the newly found one
            if (pend_nxt && pend_r && !ov_nxt) begin
              ov_nxt = 1'b1; ook_nxt = 1'b1; ocb_nxt = pcb_r; olast_nxt = 1'b1;
            end else if (ov_nxt) begin
              // previous flushed this cycle; emit current next cycle
              state_nxt = S_EXEC;
            end else begin
              ov_nxt = 1'b1; ook_nxt = pend_nxt; ocb_nxt = pend_nxt ? pcb_nxt : '0;
              olast_nxt = 1'b1;
            end
          end else if (mode_r == OP_OPEN) begin
            ov_nxt = 1'b1;
            ook_nxt = found_nxt;
            if (found_r) ohd_nxt = ohd_r;
            else if (!found_nxt) ohd_nxt = ALL_ONES;
          end else begin
            ov_nxt = 1'b1; ook_nxt = found_nxt;
          end
        end else if (mode_r == OP_OPEN && found_r) begin
          ohd_nxt = ohd_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // tail cycle of deliver_class: send the held final result
    if (state_r == S_EXEC && mode_r == OP_DELIVER_CLASS) begin
      we = 1'b0;
      ov_nxt = 1'b1; ook_nxt = 1'b1; ocb_nxt = pcb_r; olast_nxt = 1'b1;
      oent_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
      hbase_r <= HBASE_RST;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) hbase_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt; found_r <= found_nxt; n_r <= n_nxt;
    pend_r <= pend_nxt; pcb_r <= pcb_nxt;
    ook_r <= ook_nxt; olast_r <= olast_nxt; ohd_r <= ohd_nxt;
    ocb_r <= ocb_nxt; oent_r <= oent_nxt;
    if (state_r == S_IDLE && start) begin
      mode_r <= in_mode; cls_r <= in_class_id; spec_r <= in_spec_in;
      pol_r <= in_no_callback; cb_r <= in_callback_in; valid_r <= hval;
    end
  end

  assign out_valid = ov_r;
  assign out_ok = ook_r;
  assign out_handle_out = ohd_r;
  assign out_entry_class = oent_r.cls;
  assign out_entry_spec = oent_r.spec;
  assign out_entry_no_callback = oent_r.polled;
  assign out_entry_status = oent_r.status;
  assign out_callback_out = ocb_r;
  assign out_last = olast_r;

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> busy) else $error("accept during clear");
  a_res_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (n_r <= 5'(MAX_RESULTS))) else $error("too many results");
  a_idle_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_last && state_r != S_IDLE) |-> $past(state_r) == S_IDLE)
    else $error("last result while still working");

endmodule
